>>> rtl/core/circ_pkg.sv
// Shared constants and operation codes for the circle outline rasterizer.
`default_nettype none

package circ_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 14;

  localparam int PIXELS_PER_STEP = 8;
  localparam int PIX_IDX_BITS    = $clog2(PIXELS_PER_STEP);

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } circ_op_t;

endpackage

`default_nettype wire

>>> rtl/core/circ_if.sv
// Valid/ready channel interfaces for the input items and the emitted pixels.
`default_nettype none

interface circ_in_if #(
  parameter int COORD_BITS  = circ_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = circ_pkg::RADIUS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, operation, center_x, center_y, radius, input ready);
  modport sink   (input valid, operation, center_x, center_y, radius, output ready);
endinterface

interface circ_out_if #(
  parameter int COORD_BITS = circ_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  pixel_x;
  logic signed [COORD_BITS:0]  pixel_y;
  logic                        last;
  logic                        done_res;

  modport source (output valid, pixel_x, pixel_y, last, done_res, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, done_res, output ready);
endinterface

`default_nettype wire

>>> rtl/core/circle_outline_rasterizer.sv
// Circle outline rasterizer: integer midpoint-style octant walk with 8-way mirroring.
// A step item goes to the emitter snapshot; its pixels then load the output register.
// Throughput: one pixel per cycle while the output is ready; a step emits 8 pixels,
//   a finished-outline step one done result, a start item no result.
// The next item is taken in the cycle the current step's final pixel is loaded.
// Reset (synchronous, active low) clears the walk state, so a step right after reset is done.
`default_nettype none

module circle_outline_rasterizer
  import circ_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  circ_in_if.sink    in_ch,
  circ_out_if.source out_ch
);

  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int DEC_BITS = RADIUS_BITS + 3;
  localparam int WB = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  // walk state
  logic signed [COORD_BITS-1:0]  cx_r, cy_r;
  logic        [RADIUS_BITS-1:0] rad_r, x_r, y_r;
  logic signed [DEC_BITS-1:0]    d_r;

  // emitter snapshot
  logic                          busy_r;
  logic                          edone_r;
  logic        [PIX_IDX_BITS-1:0] idx_r;
  logic signed [COORD_BITS-1:0]  ecx_r, ecy_r;
  logic        [RADIUS_BITS-1:0] ex_r, ey_r;

  // output register
  logic                          ov_r;
  logic signed [OUT_BITS-1:0]    px_r, py_r;
  logic                          last_r, done_r;

  logic                          load;
  logic                          load_last;
  logic                          in_xfer;
  logic                          is_start;
  logic                          walk_done;

  logic                          swap, neg_x, neg_y;
  logic        [RADIUS_BITS-1:0] dx, dy;
  logic signed [WB-1:0]          cxw, cyw, dxw, dyw, pxw, pyw;

  logic signed [DEC_BITS-1:0]    two_x, two_y, two_ry, d_nxt;
  logic        [RADIUS_BITS-1:0] x_nxt, y_nxt;

  assign load      = busy_r && (!ov_r || out_ch.ready);
  assign load_last = load && (edone_r || (idx_r == PIX_IDX_BITS'(PIXELS_PER_STEP - 1)));
  assign in_ch.ready = !busy_r || load_last;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign is_start  = (in_ch.operation == OP_START);
  assign walk_done = (x_r >= y_r);

  // mirror selection: bit 0 swaps the offsets, bit 1 negates the column, bit 2 the row
  always_comb begin
    swap  = idx_r[0];
    neg_x = idx_r[1];
    neg_y = idx_r[2];
    dx    = swap ? ey_r : ex_r;
    dy    = swap ? ex_r : ey_r;
    cxw   = WB'(ecx_r);
    cyw   = WB'(ecy_r);
    dxw   = signed'(WB'(dx));
    dyw   = signed'(WB'(dy));
    pxw   = neg_x ? (cxw - dxw) : (cxw + dxw);
    pyw   = neg_y ? (cyw - dyw) : (cyw + dyw);
  end

  // decision update for the next octant position
  always_comb begin
    two_x  = signed'({2'b00, x_r, 1'b0});
    two_y  = signed'({2'b00, y_r, 1'b0});
    two_ry = signed'({2'b00, rad_r, 1'b0}) - two_y;
    priority if (d_r >= two_x) begin
      d_nxt = d_r - two_x - DEC_BITS'(1);
      x_nxt = x_r + RADIUS_BITS'(1);
      y_nxt = y_r;
    end else if (d_r < two_ry) begin
      d_nxt = d_r + two_y - DEC_BITS'(1);
      x_nxt = x_r;
      y_nxt = y_r - RADIUS_BITS'(1);
    end else begin
      d_nxt = d_r + two_y - two_x - DEC_BITS'(2);
      x_nxt = x_r + RADIUS_BITS'(1);
      y_nxt = y_r - RADIUS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      rad_r   <= '0;
      x_r     <= '0;
      y_r     <= '0;
      d_r     <= '0;
      busy_r  <= 1'b0;
      edone_r <= 1'b0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      // drop the shown result once taken
      if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= idx_r + PIX_IDX_BITS'(1);
        if (load_last) begin
          busy_r <= 1'b0;
        end
      end

      if (in_xfer) begin
        if (is_start) begin
          cx_r  <= in_ch.center_x;
          cy_r  <= in_ch.center_y;
          rad_r <= in_ch.radius;
          x_r   <= '0;
          y_r   <= in_ch.radius;
          d_r   <= signed'({3'b000, in_ch.radius}) - DEC_BITS'(1);
        end else begin
          busy_r  <= 1'b1;
          edone_r <= walk_done;
          idx_r   <= '0;
          if (!walk_done) begin
            x_r <= x_nxt;
            y_r <= y_nxt;
            d_r <= d_nxt;
          end
        end
      end
    end
  end

  // payload registers: snapshot and output data
  always_ff @(posedge clk) begin
    if (in_xfer && !is_start) begin
      ecx_r <= cx_r;
      ecy_r <= cy_r;
      ex_r  <= x_r;
      ey_r  <= y_r;
    end
    if (load) begin
      px_r   <= edone_r ? '0 : pxw[OUT_BITS-1:0];
      py_r   <= edone_r ? '0 : pyw[OUT_BITS-1:0];
      last_r <= load_last;
      done_r <= edone_r;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.pixel_x  = px_r;
  assign out_ch.pixel_y  = py_r;
  assign out_ch.last     = last_r;
  assign out_ch.done_res = done_r;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for circle_outline_rasterizer: directed and random outline walks.
`default_nettype none

module tb_top
  import circ_pkg::*;
;

  localparam int CW    = COORD_BITS_DEF;
  localparam int RW    = RADIUS_BITS_DEF;
  localparam int PIX_W = CW + 1;
  localparam int DEC_W = RW + 3;

  typedef struct {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic                    last;
    logic                    done;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  circ_in_if  in_ch ();
  circ_out_if out_ch ();

  circle_outline_rasterizer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Outline walk state mirrored from the block
  logic signed [CW-1:0]    ctr_col;
  logic signed [CW-1:0]    ctr_row;
  logic        [RW-1:0]    rad_q;
  logic        [RW-1:0]    walk_x;
  logic        [RW-1:0]    walk_y;
  logic signed [DEC_W-1:0] walk_d;

  pixel_t pending_pixels[$];

  int n_starts;
  int n_steps;
  int n_pixels;
  int n_done_results;
  int n_errors;
  bit src_steady;
  bit sink_steady;
  int sink_hold;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 20) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // One octant move of the integer circle walk
  function automatic void walk_advance(inout int x, inout int y, inout int d, input int rad);
    if (d >= 2 * x) begin
      d -= 2 * x + 1;
      x += 1;
    end else if (d < 2 * (rad - y)) begin
      d += 2 * y - 1;
      y -= 1;
    end else begin
      d += 2 * (y - x - 1);
      y -= 1;
      x += 1;
    end
  endfunction

  function automatic int steps_to_finish(input int rad);
    int x, y, d, n;
    x = 0;
    y = rad;
    d = rad - 1;
    n = 0;
    while (x < y) begin
      walk_advance(x, y, d, rad);
      n++;
    end
    return n;
  endfunction

  task automatic trace_outline_item(input logic op, input logic signed [CW-1:0] cx,
                                    input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
    int x, y, d, rad, ccx, ccy, k;
    int sx[8];
    int sy[8];
    pixel_t p;
    if (op == OP_START) begin
      n_starts++;
      ctr_col = cx;
      ctr_row = cy;
      rad_q   = r;
      walk_x  = '0;
      walk_y  = r;
      walk_d  = DEC_W'(int'(r) - 1);
    end else begin
      n_steps++;
      x = int'(walk_x);
      y = int'(walk_y);
      if (x >= y) begin
        p.px   = '0;
        p.py   = '0;
        p.last = 1'b1;
        p.done = 1'b1;
        pending_pixels.push_back(p);
      end else begin
        ccx = int'(ctr_col);
        ccy = int'(ctr_row);
        sx  = '{x, y, -x, -y, x, y, -x, -y};
        sy  = '{y, x, y, x, -y, -x, -y, -x};
        for (k = 0; k < 8; k++) begin
          p.px   = PIX_W'(ccx + sx[k]);
          p.py   = PIX_W'(ccy + sy[k]);
          p.last = (k == 7);
          p.done = 1'b0;
          pending_pixels.push_back(p);
        end
        rad = int'(rad_q);
        d   = int'(walk_d);
        walk_advance(x, y, d, rad);
        walk_d = DEC_W'(d);
        walk_x = RW'(x);
        walk_y = RW'(y);
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected result x=%0d y=%0d last=%0b done=%0b",
                                out_ch.pixel_x, out_ch.pixel_y, out_ch.last, out_ch.done_res));
    end else begin
      want = pending_pixels.pop_front();
      if (want.done) n_done_results++;
      else n_pixels++;
      if (out_ch.pixel_x !== want.px)
        report_mismatch($sformatf("pixel_x %0d, want %0d", out_ch.pixel_x, want.px));
      if (out_ch.pixel_y !== want.py)
        report_mismatch($sformatf("pixel_y %0d, want %0d", out_ch.pixel_y, want.py));
      if (out_ch.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
      if (out_ch.done_res !== want.done)
        report_mismatch($sformatf("done_res %0b, want %0b", out_ch.done_res, want.done));
    end
  endtask

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        trace_outline_item(in_ch.operation, in_ch.center_x, in_ch.center_y, in_ch.radius);
      if (out_ch.valid && out_ch.ready)
        check_pixel();
    end
  end

  // Output backpressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (sink_steady) begin
      out_ch.ready <= 1'b1;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ch.ready <= 1'b1;
      sink_hold = $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b0;
      sink_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int roll;
    if (src_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input circ_op_t op, input logic signed [CW-1:0] cx,
                           input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.center_x  <= cx;
    in_ch.center_y  <= cy;
    in_ch.radius    <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_step();
    send_item(OP_STEP, CW'($urandom), CW'($urandom), RW'($urandom));
  endtask

  // Hold the input until every expected result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_step_after_reset();
    send_item(OP_STEP, 16'sh7fff, -16'sh8000, '1);
    wait_drained();
  endtask

  task automatic test_zero_radius();
    send_item(OP_START, -16'sd1, 16'sd1, '0);
    send_step();
    send_step();
    wait_drained();
  endtask

  task automatic test_extreme_fields();
    send_item(OP_START, 16'sh7fff, 16'sh7fff, '1);
    repeat (3) send_step();
    // restart mid-outline from the opposite corner
    send_item(OP_START, -16'sh8000, -16'sh8000, '1);
    repeat (2) send_step();
    wait_drained();
  endtask

  task automatic test_small_circles();
    send_item(OP_START, 16'sd100, -16'sd100, 14'd1);
    repeat (steps_to_finish(1) + 1) send_step();
    send_item(OP_START, -16'sd5, 16'sd7, 14'd3);
    repeat (steps_to_finish(3) + 1) send_step();
    wait_drained();
  endtask

  task automatic test_random_outlines();
    int sent, kind, roll, n, seq;
    logic [RW-1:0] r;
    sent = 0;
    seq  = 0;
    while (sent < 110) begin
      seq++;
      roll        = $urandom_range(0, 3);
      src_steady  = (roll == 0);
      sink_steady = (roll == 0);
      kind        = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(circ_op_t'($urandom_range(0, 1)), CW'($urandom), CW'($urandom), RW'($urandom));
          sent++;
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) r = RW'($urandom_range(0, 10));
        else if (roll < 90) r = RW'($urandom_range(11, 40));
        else r = RW'($urandom_range(1000, 16383));
        n = steps_to_finish(int'(r));
        send_item(OP_START, CW'($urandom), CW'($urandom), r);
        sent++;
        // abandon some walks early so the next start lands mid-outline
        if (kind < 30 || r >= 1000) n = $urandom_range(0, (n < 4) ? n : 4);
        else n = n + $urandom_range(0, 2);
        repeat (n) begin
          send_step();
          sent++;
        end
      end
      if (seq % 8 == 0) wait_drained();
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_START;
    in_ch.center_x  = '0;
    in_ch.center_y  = '0;
    in_ch.radius    = '0;
    out_ch.ready    = 1'b0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    sink_hold       = 0;
    n_starts        = 0;
    n_steps         = 0;
    n_pixels        = 0;
    n_done_results  = 0;
    n_errors        = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_step_after_reset();
    test_zero_radius();
    test_extreme_fields();
    test_small_circles();
    test_random_outlines();

    wait_drained();
    repeat (16) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_pixels.size()));

    $display("Covered %0d start and %0d step transfers; checked %0d pixels and %0d done results.",
             n_starts, n_steps, n_pixels, n_done_results);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
